/* design/huffman_tree_bit_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// Huffman tree bit decoder assertion macros
// Shared checking macros, sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BIT_DECODER_TOP_DEFINES_SVH
`define HUFFMAN_TREE_BIT_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTBD_CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTBD_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/htbd_pkg.sv */
// ----------------------------------------------------------------------------
// Huffman tree bit decoder package
// Field widths, byte constants and the sequencer state type.
// ----------------------------------------------------------------------------
package htbd_pkg;

	localparam int NODE_W  = 9;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 4;
	localparam int OUT_W   = 8;

	localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;

	localparam logic ACT_NODE = 1'b0;
	localparam logic ACT_DATA = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_FLUSH
	} state_t;

endpackage

/* design/huffman_tree_bit_decoder_top.sv */
// A node write is accepted while idle; node index 0 also loads the root copy. A data byte
// keeps the input stalled while its used bits walk the tree and its last symbol is flushed,
// and the stall lasts longer while a full output is held. Each bit through an internal
// node needs a node memory read that depends on the previous one, so a byte is taken
// only once the walk of the byte before it is done.
// Reset puts the walk at the root; the node memory holds no reset value.
// ----------------------------------------------------------------------------
// Huffman tree bit decoder
// Node memory holds the code tree; bytes walk it one bit per cycle unless output stalls.
// ----------------------------------------------------------------------------
`include "huffman_tree_bit_decoder_top_defines.svh"

module huffman_tree_bit_decoder_top #(
	parameter int NODE_COUNT  = 512,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        action,
	input  logic [htbd_pkg::NODE_W-1:0] node_index,
	input  logic [htbd_pkg::NODE_W-1:0] node_left,
	input  logic [htbd_pkg::NODE_W-1:0] node_right,
	input  logic                        node_is_leaf,
	input  logic [htbd_pkg::BYTE_W-1:0] node_symbol,
	input  logic [htbd_pkg::BYTE_W-1:0] data_byte,
	input  logic                        byte_is_last,
	input  logic [htbd_pkg::CNT_W-1:0]  valid_bits,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [htbd_pkg::OUT_W-1:0]  symbol,
	output logic                        end_of_run
);

	import htbd_pkg::*;

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam int SYM_W = (SYMBOL_BITS < BYTE_W) ? SYMBOL_BITS : BYTE_W;

	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic              leaf;
		logic [SYM_W-1:0]  sym;
	} entry_t;

	function automatic logic [IDX_W-1:0] clamp_idx(input logic [NODE_W-1:0] n);
		return (32'(n) < NODE_COUNT) ? IDX_W'(n) : '0;
	endfunction

	entry_t mem [NODE_COUNT];

	state_t state_q, state_d;

	entry_t             rd_q;
	entry_t             ent_q;
	entry_t             root_q;
	entry_t             ent;
	logic [IDX_W-1:0]   cur_q;
	logic [IDX_W-1:0]   child_q;
	logic [IDX_W-1:0]   child_idx;
	logic [BYTE_W-1:0]  data_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   used;
	logic               last_q;
	logic               pend_q;
	logic [SYM_W-1:0]   hold_q;
	logic               hold_v_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   symbol_q;
	logic               eor_q;

	logic               accept;
	logic               wr_en;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               res_emit;
	logic               bit_emit;
	logic               emit;
	logic [SYM_W-1:0]   emit_sym;
	logic               step_read;
	logic               consume;
	logic               out_free;
	logic               go;
	logic               walk_done;
	logic               push;
	logic               push_eor;
	logic [SYM_W-1:0]   push_sym;

	assign accept   = item_valid && !item_stall;
	assign wr_en    = accept && (action == ACT_NODE) && (32'(node_index) < NODE_COUNT);
	assign out_free = !out_valid_q || !result_stall;
	assign used     = byte_is_last ? ((valid_bits > BYTE_BITS) ? BYTE_BITS : valid_bits)
	                               : BYTE_BITS;

	assign ent       = pend_q ? (rd_q.leaf ? root_q : rd_q) : ent_q;
	assign child_idx = clamp_idx(data_q[BYTE_W-1] ? ent.right : ent.left);
	assign walk_done = (rem_q == '0) && !pend_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_DATA) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!hold_v_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		res_emit   = 1'b0;
		bit_emit   = 1'b0;
		step_read  = 1'b0;
		go         = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = cur_q;
		push       = 1'b0;
		push_eor   = 1'b0;
		emit_sym   = ent_q.sym;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				rd_en      = accept && (action == ACT_DATA);
			end
			ST_LOAD: begin
			end
			ST_WALK: begin
				res_emit  = pend_q && rd_q.leaf;
				bit_emit  = !pend_q && (rem_q != '0) && ent_q.leaf;
				step_read = (rem_q != '0) && !ent.leaf;
				emit_sym  = res_emit ? rd_q.sym : ent_q.sym;
				go        = !((res_emit || bit_emit) && hold_v_q && !out_free);
				rd_en     = go && step_read;
				rd_addr   = child_idx;
				push      = go && (res_emit || bit_emit) && hold_v_q;
			end
			ST_FLUSH: begin
				push     = hold_v_q && out_free;
				push_eor = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign emit     = res_emit || bit_emit;
	assign consume  = bit_emit || step_read;
	assign push_sym = hold_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[IDX_W'(node_index)] <= '{left: node_left, right: node_right,
				leaf: node_is_leaf, sym: node_symbol[SYM_W-1:0]};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && node_index == '0) begin
			root_q <= '{left: node_left, right: node_right,
				leaf: node_is_leaf, sym: node_symbol[SYM_W-1:0]};
		end
		if (accept && action == ACT_DATA) begin
			data_q <= data_byte;
		end else if (state_q == ST_WALK && go && consume) begin
			data_q <= {data_q[BYTE_W-2:0], 1'b0};
		end
		if (state_q == ST_LOAD) begin
			ent_q <= rd_q;
		end else if (state_q == ST_WALK && go) begin
			ent_q <= ent;
		end
		if (state_q == ST_WALK && go && step_read) begin
			child_q <= child_idx;
		end
		if (state_q == ST_WALK && go && emit) begin
			hold_q <= emit_sym;
		end
		if (push) begin
			symbol_q <= OUT_W'(push_sym);
			eor_q    <= push_eor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			rem_q       <= '0;
			last_q      <= 1'b0;
			pend_q      <= 1'b0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && action == ACT_DATA) begin
				rem_q  <= used;
				last_q <= byte_is_last;
			end
			if (state_q == ST_LOAD) begin
				pend_q <= 1'b0;
			end else if (state_q == ST_WALK && go) begin
				pend_q <= step_read;
				if (consume) begin
					rem_q <= rem_q - 1'b1;
				end
				if (pend_q) begin
					cur_q <= rd_q.leaf ? '0 : child_q;
				end
				if (emit) begin
					hold_v_q <= 1'b1;
				end
			end else if (state_q == ST_FLUSH && state_d == ST_IDLE) begin
				hold_v_q <= 1'b0;
				if (last_q) begin
					cur_q <= '0;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign symbol       = symbol_q;
	assign end_of_run   = eor_q;

	`HTBD_CHK_SAME(a_rd_in_range, rd_en, 32'(rd_addr) < NODE_COUNT, "node read out of range")
	`HTBD_CHK_SAME(a_pend_walk, pend_q, state_q == ST_WALK, "child read pending outside walk")
	`HTBD_CHK_SAME(a_idle_clean, state_q == ST_IDLE, !hold_v_q, "symbol held while idle")
	`HTBD_CHK_NEXT(a_last_root, state_q == ST_FLUSH && state_d == ST_IDLE && last_q,
		cur_q == '0, "walk not at root after final byte")
	`HTBD_CHK_SAME(a_push_free, push, out_free, "result pushed into a busy output register")

endmodule

/* tb/huffman_tree_bit_decoder_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman tree bit decoder testbench
// Loads code trees node by node, then streams compressed bytes through them.
// A behavioral copy of the tree walk predicts every decoded symbol, and each
// result transaction is checked in order against those predictions. Every
// node that a walk can reach has been written, so no unwritten entry is read.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_top_tb;

	import htbd_pkg::*;

	localparam int NODES = 512;

	typedef struct {
		logic              act;
		logic [NODE_W-1:0] idx;
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic              leaf;
		logic [BYTE_W-1:0] sym;
		logic [BYTE_W-1:0] data;
		logic              is_last;
		logic [CNT_W-1:0]  vbits;
	} coded_item_t;

	typedef struct {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic              leaf;
		logic [BYTE_W-1:0] sym;
	} tree_node_t;

	typedef struct {
		logic [OUT_W-1:0] sym;
		logic             run_end;
	} decoded_t;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	logic              action;
	logic [NODE_W-1:0] node_index;
	logic [NODE_W-1:0] node_left;
	logic [NODE_W-1:0] node_right;
	logic              node_is_leaf;
	logic [BYTE_W-1:0] node_symbol;
	logic [BYTE_W-1:0] data_byte;
	logic              byte_is_last;
	logic [CNT_W-1:0]  valid_bits;
	logic              result_valid;
	logic              result_stall;
	logic [OUT_W-1:0]  symbol;
	logic              end_of_run;

	tree_node_t        code_tree[NODES];
	bit                node_known[NODES];
	logic [NODE_W-1:0] known_nodes[$];
	bit                claimed[NODES];
	logic [NODE_W-1:0] walk_node;
	decoded_t          pending_symbols[$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int items_sent;
	int node_writes;
	int bytes_sent;
	int symbols_checked;
	int fail_count;

	huffman_tree_bit_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.node_index   (node_index),
		.node_left    (node_left),
		.node_right   (node_right),
		.node_is_leaf (node_is_leaf),
		.node_symbol  (node_symbol),
		.data_byte    (data_byte),
		.byte_is_last (byte_is_last),
		.valid_bits   (valid_bits),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.symbol       (symbol),
		.end_of_run   (end_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin : result_sink
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : symbol_check
		decoded_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_symbols.size() == 0) begin
				$error("unexpected symbol %0h, end_of_run %0b", symbol, end_of_run);
				fail_count++;
			end else begin
				want = pending_symbols.pop_front();
				symbols_checked++;
				if (symbol !== want.sym) begin
					$error("symbol: expected %0h, actual %0h", want.sym, symbol);
					fail_count++;
				end
				if (end_of_run !== want.run_end) begin
					$error("end_of_run: expected %0b, actual %0b", want.run_end, end_of_run);
					fail_count++;
				end
			end
		end
	end

	function automatic void decode_byte(input logic [BYTE_W-1:0] data, input logic is_last,
			input logic [CNT_W-1:0] vbits);
		decoded_t          run[$];
		decoded_t          one;
		logic [NODE_W-1:0] n;
		int                used;
		used = 8;
		if (is_last)
			used = (vbits > BYTE_BITS) ? 8 : int'(vbits);
		for (int k = 0; k < used; k++) begin
			n = walk_node;
			one.run_end = 1'b0;
			if (code_tree[n].leaf) begin
				one.sym = code_tree[n].sym;
				run.push_back(one);
			end else begin
				n = data[7 - k] ? code_tree[n].right : code_tree[n].left;
				if (code_tree[n].leaf) begin
					one.sym = code_tree[n].sym;
					run.push_back(one);
					n = '0;
				end
				walk_node = n;
			end
		end
		if (is_last)
			walk_node = '0;
		if (run.size() > 0)
			run[run.size() - 1].run_end = 1'b1;
		foreach (run[i])
			pending_symbols.push_back(run[i]);
	endfunction

	function automatic void absorb_item(input coded_item_t it);
		if (it.act == ACT_NODE) begin
			code_tree[it.idx] = '{it.left, it.right, it.leaf, it.sym};
			if (!node_known[it.idx])
				known_nodes.push_back(it.idx);
			node_known[it.idx] = 1'b1;
			node_writes++;
		end else begin
			decode_byte(it.data, it.is_last, it.vbits);
			bytes_sent++;
		end
	endfunction

	task automatic send_item(input coded_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid   <= 1'b1;
		action       <= it.act;
		node_index   <= it.idx;
		node_left    <= it.left;
		node_right   <= it.right;
		node_is_leaf <= it.leaf;
		node_symbol  <= it.sym;
		data_byte    <= it.data;
		byte_is_last <= it.is_last;
		valid_bits   <= it.vbits;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		absorb_item(it);
		items_sent++;
	endtask

	task automatic send_node(input logic [NODE_W-1:0] idx, left, right, input logic leaf,
			input logic [BYTE_W-1:0] sym);
		coded_item_t it;
		it.act     = ACT_NODE;
		it.idx     = idx;
		it.left    = left;
		it.right   = right;
		it.leaf    = leaf;
		it.sym     = sym;
		it.data    = BYTE_W'($urandom);
		it.is_last = 1'($urandom);
		it.vbits   = CNT_W'($urandom);
		send_item(it);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] data, input logic is_last,
			input logic [CNT_W-1:0] vbits);
		coded_item_t it;
		it.act     = ACT_DATA;
		it.idx     = NODE_W'($urandom);
		it.left    = NODE_W'($urandom);
		it.right   = NODE_W'($urandom);
		it.leaf    = 1'($urandom);
		it.sym     = BYTE_W'($urandom);
		it.data    = data;
		it.is_last = is_last;
		it.vbits   = vbits;
		send_item(it);
	endtask

	task automatic load_tree(input int n_leaves, input int mix_pct);
		logic [NODE_W-1:0] pool[$];
		logic [NODE_W-1:0] idx;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		int                pick;
		claimed    = '{default: 1'b0};
		claimed[0] = 1'b1;
		if (n_leaves < 2) begin
			send_node('0, NODE_W'($urandom), NODE_W'($urandom), 1'b1, BYTE_W'($urandom));
			return;
		end
		for (int i = 0; i < n_leaves; i++) begin
			if (node_known[0] && $urandom_range(99) < mix_pct)
				send_byte(BYTE_W'($urandom), 1'b0, CNT_W'($urandom));
			do
				idx = NODE_W'($urandom_range(1, NODES - 1));
			while (claimed[idx]);
			claimed[idx] = 1'b1;
			send_node(idx, NODE_W'($urandom), NODE_W'($urandom), 1'b1, BYTE_W'($urandom));
			pool.push_back(idx);
		end
		while (pool.size() > 1) begin
			pick = $urandom_range(pool.size() - 1);
			a    = pool[pick];
			pool.delete(pick);
			pick = $urandom_range(pool.size() - 1);
			b    = pool[pick];
			pool.delete(pick);
			if (pool.size() == 0) begin
				idx = '0;
			end else begin
				do
					idx = NODE_W'($urandom_range(1, NODES - 1));
				while (claimed[idx]);
				claimed[idx] = 1'b1;
			end
			if (node_known[0] && $urandom_range(99) < mix_pct)
				send_byte(BYTE_W'($urandom), 1'b0, CNT_W'($urandom));
			send_node(idx, a, b, 1'b0, BYTE_W'($urandom));
			pool.push_back(idx);
		end
	endtask

	task automatic noise_write();
		logic [NODE_W-1:0] l;
		logic [NODE_W-1:0] r;
		logic              leaf;
		leaf = 1'($urandom_range(1));
		l    = NODE_W'($urandom);
		r    = NODE_W'($urandom);
		if (!leaf) begin
			l = known_nodes[$urandom_range(known_nodes.size() - 1)];
			r = known_nodes[$urandom_range(known_nodes.size() - 1)];
		end
		send_node(NODE_W'($urandom_range(NODES - 1)), l, r, leaf, BYTE_W'($urandom));
	endtask

	task automatic send_stream(input int n_bytes);
		logic [CNT_W-1:0] vbits;
		for (int i = 1; i < n_bytes; i++)
			send_byte(BYTE_W'($urandom), 1'b0, CNT_W'($urandom));
		vbits = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(0, 15))
		                                 : CNT_W'($urandom_range(1, 8));
		send_byte(BYTE_W'($urandom), 1'b1, vbits);
	endtask

	task automatic test_leaf_at_root();
		send_node('0, '1, '1, 1'b1, 8'hA5);
		send_byte(8'h00, 1'b0, 4'd0);
		send_byte(8'hFF, 1'b1, 4'd3);
		send_byte(8'h5A, 1'b1, 4'd0);
		send_byte(8'h3C, 1'b1, 4'd15);
	endtask

	task automatic test_looping_tree();
		send_node(9'd511, '0, '1, 1'b1, 8'h00);
		send_node(9'd2, '1, '0, 1'b1, 8'hFF);
		send_node(9'd1, '0, 9'd2, 1'b0, 8'h00);
		send_node('0, 9'd511, 9'd1, 1'b0, 8'h00);
		send_byte(8'h00, 1'b0, 4'd0);
		send_byte(8'hFF, 1'b0, 4'd0);
		send_byte(8'h80, 1'b0, 4'd0);
		send_byte(8'hAA, 1'b0, 4'd0);
		send_byte(8'h01, 1'b0, 4'd0);
		send_byte(8'h80, 1'b1, 4'd1);
		send_byte(8'h01, 1'b0, 4'd0);
		send_byte(8'h00, 1'b1, 4'd0);
		send_byte(8'hC0, 1'b1, 4'd2);
		send_byte(8'hFF, 1'b1, 4'd8);
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_tree(2, 0);
		hold_left = 400;
		send_stream(30);
	endtask

	task automatic test_random_streams(input int s_pct, input int r_pct, input int n_items);
		int stop_at;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		stop_at       = items_sent + n_items;
		while (items_sent < stop_at) begin
			load_tree(($urandom_range(9) == 0) ? 1 : $urandom_range(2, 10), 15);
			if ($urandom_range(9) == 0)
				noise_write();
			send_stream($urandom_range(4, 16));
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		action          = ACT_NODE;
		node_index      = '0;
		node_left       = '0;
		node_right      = '0;
		node_is_leaf    = 1'b0;
		node_symbol     = '0;
		data_byte       = '0;
		byte_is_last    = 1'b0;
		valid_bits      = '0;
		walk_node       = '0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		hold_left       = 0;
		items_sent      = 0;
		node_writes     = 0;
		bytes_sent      = 0;
		symbols_checked = 0;
		fail_count      = 0;
		node_known      = '{default: 1'b0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_leaf_at_root();
		test_looping_tree();
		test_output_backpressure();
		test_random_streams(20, 70, 100);
		test_random_streams(70, 20, 100);
		test_random_streams(0, 0, 80);

		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("summary: %0d transactions sent, %0d node writes and %0d data bytes",
			items_sent, node_writes, bytes_sent);
		$display("summary: %0d symbols checked, %0d mismatches", symbols_checked, fail_count);
		if (fail_count == 0 && pending_symbols.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
